[hw/rtl/sae_pkg.sv]
package sae_pkg;

   localparam int unsigned CodeWidth   = 8;
   localparam int unsigned CharWidth   = 7;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned ColumnWidth = 7;
   localparam int unsigned CursorWidth = 9;
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [CodeWidth-1:0] ScLshiftMake  = 8'h2A;
   localparam logic [CodeWidth-1:0] ScRshiftMake  = 8'h36;
   localparam logic [CodeWidth-1:0] ScLshiftBreak = 8'hAA;
   localparam logic [CodeWidth-1:0] ScRshiftBreak = 8'hB6;
   localparam logic [CodeWidth-1:0] ScEnter       = 8'h1C;
   localparam logic [CodeWidth-1:0] ScBackspace   = 8'h0E;
   localparam int unsigned          ScReleaseBit  = 7;

   localparam logic [CountWidth-1:0]  MaxLineReset  = 8'd80;
   localparam logic [ColumnWidth-1:0] StartColReset = 7'd2;

   typedef enum logic [0:0] {
      CSR_MAX_LINE_LENGTH = 1'b0,
      CSR_START_COLUMN    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_ERASE = 2'd2,
      KIND_ENTER = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_IGNORED = 3'd0,
      EV_STORED  = 3'd1,
      EV_ERASED  = 3'd2,
      EV_ENDED   = 3'd3,
      EV_FULL    = 3'd4
   } event_type;

   // one classified key action, passed from front to back
   typedef struct packed {
      kind_type               kind;
      logic [CharWidth-1:0]   char_code;
   } action_type;

   function automatic logic [CharWidth-1:0] plain_char(input logic [5:0] code);
      logic [CharWidth-1:0] ch;
      unique case (code)
         6'h02: ch = 7'h31;  6'h03: ch = 7'h32;  6'h04: ch = 7'h33;  6'h05: ch = 7'h34;
         6'h06: ch = 7'h35;  6'h07: ch = 7'h36;  6'h08: ch = 7'h37;  6'h09: ch = 7'h38;
         6'h0A: ch = 7'h39;  6'h0B: ch = 7'h30;  6'h0C: ch = 7'h2D;  6'h0D: ch = 7'h3D;
         6'h10: ch = 7'h71;  6'h11: ch = 7'h77;  6'h12: ch = 7'h65;  6'h13: ch = 7'h72;
         6'h14: ch = 7'h74;  6'h15: ch = 7'h79;  6'h16: ch = 7'h75;  6'h17: ch = 7'h69;
         6'h18: ch = 7'h6F;  6'h19: ch = 7'h70;  6'h1A: ch = 7'h5B;  6'h1B: ch = 7'h5D;
         6'h1E: ch = 7'h61;  6'h1F: ch = 7'h73;  6'h20: ch = 7'h64;  6'h21: ch = 7'h66;
         6'h22: ch = 7'h67;  6'h23: ch = 7'h68;  6'h24: ch = 7'h6A;  6'h25: ch = 7'h6B;
         6'h26: ch = 7'h6C;  6'h27: ch = 7'h3B;  6'h28: ch = 7'h27;  6'h2B: ch = 7'h5C;
         6'h2C: ch = 7'h7A;  6'h2D: ch = 7'h78;  6'h2E: ch = 7'h63;  6'h2F: ch = 7'h76;
         6'h30: ch = 7'h62;  6'h31: ch = 7'h6E;  6'h32: ch = 7'h6D;  6'h33: ch = 7'h2C;
         6'h34: ch = 7'h2E;  6'h35: ch = 7'h2F;  6'h39: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

   function automatic logic [CharWidth-1:0] shift_char(input logic [5:0] code);
      logic [CharWidth-1:0] ch;
      unique case (code)
         6'h02: ch = 7'h21;  6'h03: ch = 7'h40;  6'h04: ch = 7'h23;  6'h05: ch = 7'h24;
         6'h06: ch = 7'h25;  6'h07: ch = 7'h5E;  6'h08: ch = 7'h26;  6'h09: ch = 7'h2A;
         6'h0A: ch = 7'h28;  6'h0B: ch = 7'h29;  6'h0C: ch = 7'h5F;  6'h0D: ch = 7'h2B;
         6'h10: ch = 7'h51;  6'h11: ch = 7'h57;  6'h12: ch = 7'h45;  6'h13: ch = 7'h52;
         6'h14: ch = 7'h54;  6'h15: ch = 7'h59;  6'h16: ch = 7'h55;  6'h17: ch = 7'h49;
         6'h18: ch = 7'h4F;  6'h19: ch = 7'h50;  6'h1A: ch = 7'h7B;  6'h1B: ch = 7'h7D;
         6'h1E: ch = 7'h41;  6'h1F: ch = 7'h53;  6'h20: ch = 7'h44;  6'h21: ch = 7'h46;
         6'h22: ch = 7'h47;  6'h23: ch = 7'h48;  6'h24: ch = 7'h4A;  6'h25: ch = 7'h4B;
         6'h26: ch = 7'h4C;  6'h27: ch = 7'h3A;  6'h28: ch = 7'h22;  6'h2B: ch = 7'h7C;
         6'h2C: ch = 7'h5A;  6'h2D: ch = 7'h58;  6'h2E: ch = 7'h43;  6'h2F: ch = 7'h56;
         6'h30: ch = 7'h42;  6'h31: ch = 7'h4E;  6'h32: ch = 7'h4D;  6'h33: ch = 7'h3C;
         6'h34: ch = 7'h3E;  6'h35: ch = 7'h3F;  6'h39: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

[hw/rtl/scancode_to_ascii_line_editor.sv]
// Set 1 keyboard scan codes in, line-edit events out: one result beat for
// every scan code beat. The front stage tracks the shift keys and maps make
// codes to US ASCII in the cycle a beat is taken; a two-entry queue feeds the
// back stage, which keeps the line length, applies the length limit and
// registers the result. A beat passes through a queue entry and the result
// register; the block sustains one beat per cycle and stalls only when the
// result side holds rsp_tready low long enough to fill the queue. Registers:
// index 0 is the maximum line length (reset 80), index 1 the start column
// (reset 2); write them only while no beats are in flight.
module scancode_to_ascii_line_editor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] scan_code
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [6:0] char_code, [14:7] char_index, [22:15] line_length, [31:23] cursor_column
   output logic [31:0]                          rsp_tdata,
   output logic [2:0]                           rsp_tuser,  // [2:0] event_res
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [0:0]                           csr_index,
   input  logic [7:0]                           csr_data
);

   sae_pkg::action_type                     front_act;
   sae_pkg::action_type                     queue_act;
   logic                                    queue_full;
   logic                                    queue_valid;
   logic                                    queue_pop;
   logic                                    req_accept;
   sae_pkg::event_type                      res_event;
   logic [sae_pkg::CharWidth-1:0]           res_char;
   logic [sae_pkg::CountWidth-1:0]          res_index;
   logic [sae_pkg::CountWidth-1:0]          res_length;
   logic [sae_pkg::CursorWidth-1:0]         res_cursor;

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   sae_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .scan_code (req_tdata),
      .action    (front_act)
   );

   sae_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_act),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_data  (queue_act)
   );

   sae_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (sae_pkg::csr_index_type'(csr_index)),
      .csr_data   (csr_data),
      .act_valid  (queue_valid),
      .act        (queue_act),
      .act_pop    (queue_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_event  (res_event),
      .out_char   (res_char),
      .out_index  (res_index),
      .out_length (res_length),
      .out_cursor (res_cursor)
   );

   assign rsp_tdata = {res_cursor, res_length, res_index, res_char};
   assign rsp_tuser = res_event;

endmodule

[hw/rtl/sae_front.sv]
module sae_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [sae_pkg::CodeWidth-1:0]     scan_code,
   output sae_pkg::action_type               action
);

   logic                             shift_ff;
   logic                             shift_in;
   logic [sae_pkg::CharWidth-1:0]    mapped;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      shift_in         = shift_ff;
      mapped           = '0;
      action.kind      = sae_pkg::KIND_NONE;
      action.char_code = '0;
      priority if (scan_code == sae_pkg::ScLshiftMake || scan_code == sae_pkg::ScRshiftMake) begin
         if (accept) begin
            shift_in = 1'b1;
         end
      end else if (scan_code == sae_pkg::ScLshiftBreak ||
                   scan_code == sae_pkg::ScRshiftBreak) begin
         if (accept) begin
            shift_in = 1'b0;
         end
      end else if (scan_code[sae_pkg::ScReleaseBit]) begin
         action.kind = sae_pkg::KIND_NONE;
      end else if (scan_code == sae_pkg::ScEnter) begin
         action.kind = sae_pkg::KIND_ENTER;
      end else if (scan_code == sae_pkg::ScBackspace) begin
         action.kind = sae_pkg::KIND_ERASE;
      end else begin
         // only codes below 0x40 have a mapping
         if (!scan_code[6]) begin
            mapped = shift_ff ? sae_pkg::shift_char(scan_code[5:0])
                              : sae_pkg::plain_char(scan_code[5:0]);
         end
         if (mapped != '0) begin
            action.kind      = sae_pkg::KIND_CHAR;
            action.char_code = mapped;
         end
      end
   end

endmodule

[hw/rtl/sae_queue.sv]
module sae_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sae_pkg::action_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output sae_pkg::action_type  pop_data
);

   sae_pkg::action_type                    store_ff [sae_pkg::QueueDepth];
   logic [sae_pkg::QueuePtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sae_pkg::QueuePtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sae_pkg::QueueCntWidth-1:0]      count_ff, count_in;

   localparam logic [sae_pkg::QueueCntWidth-1:0] DepthCount =
      sae_pkg::QueueCntWidth'(sae_pkg::QueueDepth);
   localparam logic [sae_pkg::QueuePtrWidth-1:0] LastPtr =
      sae_pkg::QueuePtrWidth'(sae_pkg::QueueDepth - 1);

   assign full      = (count_ff == DepthCount);
   assign not_empty = (count_ff != '0);
   assign pop_data  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/sae_back.sv]
module sae_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  sae_pkg::csr_index_type              csr_index,
   input  logic [sae_pkg::CountWidth-1:0]      csr_data,
   input  logic                                act_valid,
   input  sae_pkg::action_type                 act,
   output logic                                act_pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output sae_pkg::event_type                  out_event,
   output logic [sae_pkg::CharWidth-1:0]       out_char,
   output logic [sae_pkg::CountWidth-1:0]      out_index,
   output logic [sae_pkg::CountWidth-1:0]      out_length,
   output logic [sae_pkg::CursorWidth-1:0]     out_cursor
);

   logic [sae_pkg::CountWidth-1:0]   max_len_ff, max_len_in;
   logic [sae_pkg::ColumnWidth-1:0]  start_col_ff, start_col_in;
   logic [sae_pkg::CountWidth-1:0]   count_ff, count_in;
   logic                             valid_ff, valid_in;

   sae_pkg::event_type               ev_ff, ev_in;
   logic [sae_pkg::CharWidth-1:0]    char_ff, char_in;
   logic [sae_pkg::CountWidth-1:0]   index_ff, index_in;
   logic [sae_pkg::CountWidth-1:0]   length_ff;
   logic [sae_pkg::CursorWidth-1:0]  cursor_ff, cursor_in;

   assign act_pop    = act_valid && (!valid_ff || out_ready);
   assign out_valid  = valid_ff;
   assign out_event  = ev_ff;
   assign out_char   = char_ff;
   assign out_index  = index_ff;
   assign out_length = length_ff;
   assign out_cursor = cursor_ff;

   always_comb begin
      max_len_in   = max_len_ff;
      start_col_in = start_col_ff;
      if (csr_write) begin
         unique case (csr_index)
            sae_pkg::CSR_MAX_LINE_LENGTH: max_len_in   = csr_data;
            sae_pkg::CSR_START_COLUMN:    start_col_in = csr_data[sae_pkg::ColumnWidth-1:0];
            default:                      max_len_in   = max_len_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      ev_in    = sae_pkg::EV_IGNORED;
      char_in  = '0;
      index_in = '0;
      unique case (act.kind)
         sae_pkg::KIND_ENTER: begin
            ev_in    = sae_pkg::EV_ENDED;
            index_in = count_ff;
            count_in = '0;
         end
         sae_pkg::KIND_ERASE: begin
            if (count_ff != '0) begin
               ev_in    = sae_pkg::EV_ERASED;
               count_in = count_ff - 1'b1;
               index_in = count_ff - 1'b1;
            end
         end
         sae_pkg::KIND_CHAR: begin
            if (count_ff < max_len_ff) begin
               ev_in    = sae_pkg::EV_STORED;
               char_in  = act.char_code;
               index_in = count_ff;
               count_in = count_ff + 1'b1;
            end else begin
               ev_in = sae_pkg::EV_FULL;
            end
         end
         default: ev_in = sae_pkg::EV_IGNORED;
      endcase
      cursor_in = {2'b00, start_col_ff} + {1'b0, count_in};
      if (!act_pop) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (act_pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= sae_pkg::MaxLineReset;
         start_col_ff <= sae_pkg::StartColReset;
         count_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         start_col_ff <= start_col_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (act_pop) begin
         ev_ff     <= ev_in;
         char_ff   <= char_in;
         index_ff  <= index_in;
         length_ff <= count_in;
         cursor_ff <= cursor_in;
      end
   end

endmodule

[test/tb_scancode_to_ascii_line_editor.sv]
module tb_scancode_to_ascii_line_editor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 50000;
   localparam byte unsigned NoKey = 8'h7E;

   localparam logic [7:0] Key1        = 8'h02;
   localparam logic [7:0] KeyTab      = 8'h0F;
   localparam logic [7:0] KeyQ        = 8'h10;
   localparam logic [7:0] KeyW        = 8'h11;
   localparam logic [7:0] KeyA        = 8'h1E;
   localparam logic [7:0] KeyBacktick = 8'h29;
   localparam logic [7:0] KeySpace    = 8'h39;
   localparam logic [7:0] KeyCaps     = 8'h3A;
   localparam logic [7:0] KeyPageUp   = 8'h49;
   localparam logic [7:0] KeyPageDown = 8'h51;
   localparam logic [7:0] ReleaseMask = 8'h80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // ascii per make code 0x00..0x3f, tilde marks an unmapped key
   string plain_keys = {"~~1234567890-=~~", "qwertyuiop[]~~as",
                        "dfghjkl;'~~\\zxcv", "bnm,./~~~ ~~~~~~"};
   string shift_keys = {"~~!@#$%^&*()_+~~", "QWERTYUIOP{}~~AS",
                        "DFGHJKL:\"~~|ZXCV", "BNM<>?~~~ ~~~~~~"};

   typedef struct {
      sae_pkg::event_type ev;
      logic [6:0]         ch;
      logic [7:0]         idx;
      logic [7:0]         len;
      logic [8:0]         col;
   } line_event_type;

   // line editor state as the block should hold it
   logic [7:0] max_len    = sae_pkg::MaxLineReset;
   logic [6:0] start_col  = sae_pkg::StartColReset;
   logic       shift_down = 1'b0;
   logic [7:0] line_len   = '0;

   logic [7:0]     scan_queue[$];
   line_event_type pending_events[$];

   int errors = 0;
   int cycles = 0;
   int codes_sent = 0;
   int longest = 0;
   int settings_used = 1;
   int event_tally[5] = '{default: 0};
   bit idle_on = 1'b1;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_accepted = 1'b0;
   bit rsp_accepted = 1'b0;

   always #5 clock = ~clock;

   scancode_to_ascii_line_editor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   task automatic flag_error(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("%s: got %0h, expected %0h (beat %0d)", name, got, want,
                              codes_sent));
   endtask

   function automatic line_event_type edit_line(input logic [7:0] code);
      line_event_type res;
      byte unsigned key;
      res.ev  = sae_pkg::EV_IGNORED;
      res.ch  = '0;
      res.idx = '0;
      key     = NoKey;
      if (code == sae_pkg::ScLshiftMake || code == sae_pkg::ScRshiftMake) begin
         shift_down = 1'b1;
      end else if (code == sae_pkg::ScLshiftBreak || code == sae_pkg::ScRshiftBreak) begin
         shift_down = 1'b0;
      end else if (!code[sae_pkg::ScReleaseBit]) begin
         if (code == sae_pkg::ScEnter) begin
            res.ev   = sae_pkg::EV_ENDED;
            res.idx  = line_len;
            line_len = '0;
         end else if (code == sae_pkg::ScBackspace) begin
            if (line_len != 0) begin
               line_len = line_len - 8'd1;
               res.ev   = sae_pkg::EV_ERASED;
               res.idx  = line_len;
            end
         end else begin
            if (code < 8'd64)
               key = shift_down ? shift_keys[code] : plain_keys[code];
            if (key != NoKey) begin
               if (line_len < max_len) begin
                  res.ev   = sae_pkg::EV_STORED;
                  res.ch   = key[6:0];
                  res.idx  = line_len;
                  line_len = line_len + 8'd1;
               end else begin
                  res.ev = sae_pkg::EV_FULL;
               end
            end
         end
      end
      res.len = line_len;
      res.col = 9'(start_col) + 9'(line_len);
      return res;
   endfunction

   function automatic logic [7:0] random_key();
      logic [7:0] code;
      do
         code = 8'($urandom_range(Key1, KeySpace));
      while (plain_keys[code] == NoKey);
      return code;
   endfunction

   // sample handshakes, predict and check
   always @(posedge clock) begin
      line_event_type want;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("ERROR: timed out after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         req_accepted <= req_tvalid && req_tready;
         rsp_accepted <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               flag_error($sformatf("result beat with nothing expected: event %0d data %h",
                                    rsp_tuser, rsp_tdata));
            end else begin
               want = pending_events.pop_front();
               check_field("event_res", 32'(rsp_tuser), 32'(want.ev));
               check_field("char_code", 32'(rsp_tdata[6:0]), 32'(want.ch));
               check_field("char_index", 32'(rsp_tdata[14:7]), 32'(want.idx));
               check_field("line_length", 32'(rsp_tdata[22:15]), 32'(want.len));
               check_field("cursor_column", 32'(rsp_tdata[31:23]), 32'(want.col));
            end
         end
         if (req_tvalid && req_tready) begin
            want = edit_line(req_tdata);
            pending_events.push_back(want);
            event_tally[int'(want.ev)]++;
            codes_sent++;
            if (int'(want.len) > longest)
               longest = int'(want.len);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == sae_pkg::CSR_MAX_LINE_LENGTH)
               max_len = csr_data;
            else
               start_col = csr_data[6:0];
         end
      end
   end

   // scan code driver and result-side stalls
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_accepted) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (scan_queue.size() > 0) begin
               req_tdata  <= scan_queue.pop_front();
               req_tvalid <= 1'b1;
               req_gap = idle_on ? $urandom_range(0, 3) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_accepted)
            rsp_stall = idle_on ? $urandom_range(0, 3) : 0;
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // checked at the rising edge, where the driver's queue and valid are settled
   task automatic wait_idle();
      do
         @(posedge clock);
      while (scan_queue.size() != 0 || req_tvalid || pending_events.size() != 0);
   endtask

   task automatic write_reg(input sae_pkg::csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_registers(input logic [7:0] max_value, input logic [6:0] column);
      wait_idle();
      write_reg(sae_pkg::CSR_MAX_LINE_LENGTH, max_value);
      write_reg(sae_pkg::CSR_START_COLUMN, {1'b0, column});
      settings_used++;
   endtask

   // typing with random content, plus shifts, releases, edits and raw noise
   task automatic gen_typing(input int count, input int enter_pct);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < enter_pct)
            scan_queue.push_back(sae_pkg::ScEnter);
         else if (r < enter_pct + 6)
            scan_queue.push_back(sae_pkg::ScBackspace);
         else if (r < enter_pct + 10)
            scan_queue.push_back($urandom_range(0, 1) ? sae_pkg::ScLshiftMake
                                                      : sae_pkg::ScRshiftMake);
         else if (r < enter_pct + 14)
            scan_queue.push_back($urandom_range(0, 1) ? sae_pkg::ScLshiftBreak
                                                      : sae_pkg::ScRshiftBreak);
         else if (r < enter_pct + 19)
            scan_queue.push_back(ReleaseMask | 8'($urandom_range(0, 127)));
         else if (r < enter_pct + 24)
            scan_queue.push_back(8'($urandom_range(0, 255)));
         else
            scan_queue.push_back(random_key());
      end
   endtask

   task automatic run_phase(input logic [7:0] max_value, input logic [6:0] column,
                            input bit idle, input int fill, input int count,
                            input int enter_pct);
      set_registers(max_value, column);
      idle_on = idle;
      for (int i = 0; i < fill; i++)
         scan_queue.push_back(random_key());
      gen_typing(count, enter_pct);
   endtask

   initial begin
      logic [7:0] opening[] = '{sae_pkg::ScBackspace, 8'h00, 8'h7F, 8'h80, 8'hFF,
                                KeyPageUp, KeyPageDown, KeyTab, KeyBacktick, KeyCaps,
                                KeyA, sae_pkg::ScLshiftMake, KeyA, KeyA | ReleaseMask,
                                sae_pkg::ScLshiftBreak, sae_pkg::ScRshiftMake, Key1,
                                sae_pkg::ScRshiftBreak, KeySpace, sae_pkg::ScBackspace,
                                sae_pkg::ScEnter};
      logic [7:0] tiny_line[] = '{KeyQ, KeyW, sae_pkg::ScBackspace, sae_pkg::ScEnter};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      foreach (opening[i])
         scan_queue.push_back(opening[i]);
      // one-character line at the far right column
      set_registers(8'd1, 7'd79);
      foreach (tiny_line[i])
         scan_queue.push_back(tiny_line[i]);
      run_phase(8'd80, 7'd2, 1'b1, 0, 100, 3);
      // longest line, then typing into a full line
      run_phase(8'd255, 7'd79, 1'b0, 260, 40, 0);
      // limit lowered below the length left from the long line
      run_phase(8'd3, 7'd0, 1'b1, 0, 80, 5);
      run_phase(8'd0, 7'd40, 1'b0, 0, 30, 5);
      run_phase(8'd1, 7'd79, 1'b1, 0, 40, 8);
      run_phase(8'd17, 7'd63, 1'b1, 0, 80, 4);
      wait_idle();
      repeat (8) @(posedge clock);
      if (pending_events.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_events.size()));
      $display("run covered %0d scan codes over %0d register settings, longest line %0d",
               codes_sent, settings_used, longest);
      $display("events: ignored %0d stored %0d erased %0d ended %0d full %0d",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3],
               event_tally[4]);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/sae_pkg.sv
hw/rtl/sae_front.sv
hw/rtl/sae_queue.sv
hw/rtl/sae_back.sv
hw/rtl/scancode_to_ascii_line_editor.sv
test/tb_scancode_to_ascii_line_editor.sv
